// ----- src/gss_pkg.sv -----
package gss_pkg;

    localparam int TimerW   = 16;
    localparam int RpmW     = 14;
    localparam int SpeedW   = 8;
    localparam int GearW    = 3;
    localparam int ShiftW   = 16;
    localparam int TimeW    = 32;
    localparam int DivSteps = RpmW;
    localparam int DivCntW  = $clog2(DivSteps);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE
    } gss_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } gss_cmd_t;

    // Gear from the rpm-to-speed ratio; every band bound is exclusive.
    function automatic logic [GearW-1:0] gear_band(input logic [RpmW-1:0] r);
        logic [GearW-1:0] g;
        g = 3'd0;
        if (r > 14'd110 && r < 14'd200) g = 3'd1;
        else if (r > 14'd65 && r < 14'd100) g = 3'd2;
        else if (r > 14'd42 && r < 14'd60) g = 3'd3;
        else if (r > 14'd34 && r < 14'd41) g = 3'd4;
        else if (r > 14'd25 && r < 14'd31) g = 3'd5;
        return g;
    endfunction

endpackage

// ----- src/gss_sample_if.sv -----
interface gss_sample_if
    import gss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TimerW-1:0] timer_capture;
    logic [RpmW-1:0]   engine_rpm;
    logic [SpeedW-1:0] speed_kmh;
    logic              speed_valid;

    modport source (output valid, output timer_capture, output engine_rpm,
                    output speed_kmh, output speed_valid, input ready);
    modport sink   (input valid, input timer_capture, input engine_rpm,
                    input speed_kmh, input speed_valid, output ready);
endinterface

// ----- src/gss_result_if.sv -----
interface gss_result_if
    import gss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [GearW-1:0]  gear_now;
    logic [ShiftW-1:0] shift_total;
    logic [SpeedW-1:0] peak_speed;
    logic [RpmW-1:0]   peak_rpm;
    logic [TimeW-1:0]  elapsed_counts;

    modport source (output valid, output gear_now, output shift_total,
                    output peak_speed, output peak_rpm, output elapsed_counts,
                    input ready);
    modport sink   (input valid, input gear_now, input shift_total,
                    input peak_speed, input peak_rpm, input elapsed_counts,
                    output ready);
endinterface

// ----- src/gss_ctrl.sv -----
module gss_ctrl
    import gss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output gss_cmd_t cmd
);

    gss_state_t         state_reg, state_next;
    logic [DivCntW-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                count_next = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == DivCntW'(DivSteps - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // The result register must be free before it is overwritten.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- src/gss_datapath.sv -----
module gss_datapath
    import gss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gss_cmd_t          cmd,
    input  logic              cfg_we,
    input  logic [TimeW-1:0]  cfg_wdata,
    input  logic [TimerW-1:0] timer_capture,
    input  logic [RpmW-1:0]   engine_rpm,
    input  logic [SpeedW-1:0] speed_kmh,
    input  logic              speed_valid,
    output logic [GearW-1:0]  gear_now,
    output logic [ShiftW-1:0] shift_total,
    output logic [SpeedW-1:0] peak_speed,
    output logic [RpmW-1:0]   peak_rpm,
    output logic [TimeW-1:0]  elapsed_counts
);

    // Block state.
    logic [TimeW-1:0]  holdoff_reg;
    logic [TimerW-1:0] last_capture_reg;
    logic [TimeW-1:0]  elapsed_reg;
    logic [GearW-1:0]  last_gear_reg;
    logic [TimeW-1:0]  last_shift_reg;
    logic [ShiftW-1:0] shift_cnt_reg;
    logic [SpeedW-1:0] speed_peak_reg;
    logic [RpmW-1:0]   rpm_peak_reg;

    // Sample held during the division.
    logic [RpmW-1:0]   rpm_reg;
    logic [SpeedW-1:0] speed_reg;
    logic              valid_reg;
    logic [RpmW-1:0]   quot_reg;
    logic [SpeedW-1:0] rem_reg;

    // Result register.
    logic [GearW-1:0]  res_gear_reg;
    logic [ShiftW-1:0] res_shift_reg;
    logic [SpeedW-1:0] res_speed_reg;
    logic [RpmW-1:0]   res_rpm_reg;
    logic [TimeW-1:0]  res_time_reg;

    logic [TimerW-1:0] delta;
    logic [SpeedW:0]   rem_shift;
    logic              rem_ge;
    logic [GearW-1:0]  gear;
    logic              holdoff_ok;
    logic              do_shift;
    logic [SpeedW-1:0] speed_peak_next;
    logic [RpmW-1:0]   rpm_peak_next;

    always_comb
    begin
        delta     = timer_capture - last_capture_reg;
        rem_shift = {rem_reg, quot_reg[RpmW-1]};
        rem_ge    = rem_shift >= {1'b0, speed_reg};

        gear = '0;
        if (valid_reg && speed_reg != '0)
            gear = gear_band(quot_reg);
        holdoff_ok = (elapsed_reg - last_shift_reg) > holdoff_reg;
        do_shift   = gear != '0 && gear != last_gear_reg && holdoff_ok;

        speed_peak_next = speed_peak_reg;
        if (valid_reg && speed_reg > speed_peak_reg)
            speed_peak_next = speed_reg;
        rpm_peak_next = (rpm_reg > rpm_peak_reg) ? rpm_reg : rpm_peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg      <= '0;
            last_capture_reg <= '0;
            elapsed_reg      <= '0;
            last_gear_reg    <= '0;
            last_shift_reg   <= '0;
            shift_cnt_reg    <= '0;
            speed_peak_reg   <= '0;
            rpm_peak_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                holdoff_reg <= cfg_wdata;
            if (cmd.load && engine_rpm != '0)
            begin
                elapsed_reg      <= elapsed_reg + TimeW'(delta);
                last_capture_reg <= timer_capture;
            end
            if (cmd.commit)
            begin
                if (do_shift)
                begin
                    shift_cnt_reg  <= shift_cnt_reg + 1'b1;
                    last_gear_reg  <= gear;
                    last_shift_reg <= elapsed_reg;
                end
                speed_peak_reg <= speed_peak_next;
                rpm_peak_reg   <= rpm_peak_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rpm_reg   <= engine_rpm;
            speed_reg <= speed_kmh;
            valid_reg <= speed_valid;
            quot_reg  <= engine_rpm;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            // Restoring division, one quotient bit per cycle.
            quot_reg <= {quot_reg[RpmW-2:0], rem_ge};
            if (rem_ge)
                rem_reg <= SpeedW'(rem_shift - {1'b0, speed_reg});
            else
                rem_reg <= rem_shift[SpeedW-1:0];
        end
        if (cmd.commit)
        begin
            res_gear_reg  <= gear;
            res_shift_reg <= do_shift ? shift_cnt_reg + 1'b1 : shift_cnt_reg;
            res_speed_reg <= speed_peak_next;
            res_rpm_reg   <= rpm_peak_next;
            res_time_reg  <= elapsed_reg;
        end
    end

    assign gear_now       = res_gear_reg;
    assign shift_total    = res_shift_reg;
    assign peak_speed     = res_speed_reg;
    assign peak_rpm       = res_rpm_reg;
    assign elapsed_counts = res_time_reg;

endmodule

// ----- src/gear_shift_statistics.sv -----
// Each item passes through an accept state, the 14-step serial rpm by speed
// divider and an update state; a new sample is taken only after that update.
// A finished result waits in an output register while the next item is taken.
// Reset (rst_n, asynchronous, active low) clears all statistics and the holdoff.
module gear_shift_statistics
    import gss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gss_sample_if.sink         sample,
    gss_result_if.source       result,
    input  logic               cfg_we,
    input  logic [TimeW-1:0]   cfg_wdata
);

    // Commands from the controller to the datapath: load a sample, take one
    // division step, and commit the statistics update into the result register.
    gss_cmd_t cmd;

    // The controller sequences each item through accept, division and update.
    // It also owns the result valid flag so that an update waits until the
    // previous result has been taken.
    gss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // The datapath holds the time accumulator, the divider, the gear bands,
    // the shift counter with its holdoff, the peak trackers and the result.
    // Elapsed time is updated when a sample with nonzero rpm is loaded, so the
    // gear decision at commit sees the time already advanced by that sample.
    gss_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .timer_capture  (sample.timer_capture),
        .engine_rpm     (sample.engine_rpm),
        .speed_kmh      (sample.speed_kmh),
        .speed_valid    (sample.speed_valid),
        .gear_now       (result.gear_now),
        .shift_total    (result.shift_total),
        .peak_speed     (result.peak_speed),
        .peak_rpm       (result.peak_rpm),
        .elapsed_counts (result.elapsed_counts)
    );

endmodule
